[rtl/core/scmd_pkg.sv]
`timescale 1ns / 1ps

package scmd_pkg;

   // Sync pattern, oldest byte first
   localparam logic [7:0] SYNC_A = 8'hAA;
   localparam logic [7:0] SYNC_B = 8'h44;
   localparam logic [7:0] SYNC_C = 8'h12;

   localparam logic [31:0] POLY_RESET = 32'hEDB8_8320;

   // Offsets of the captured header fields (little endian)
   localparam logic [16:0] OFS_ID_LO  = 17'd4;
   localparam logic [16:0] OFS_ID_HI  = 17'd5;
   localparam logic [16:0] OFS_LEN_LO = 17'd8;
   localparam logic [16:0] OFS_LEN_HI = 17'd9;
   localparam logic [16:0] OFS_SYNC_C = 17'd2;
   localparam logic [16:0] OFS_AFTER_SYNC = 17'd3;

   // Frame phase codes as reported on the result channel
   localparam logic [1:0] FRAME_PHASE_HUNT  = 2'd0;
   localparam logic [1:0] FRAME_PHASE_HEAD  = 2'd1;
   localparam logic [1:0] FRAME_PHASE_BODY  = 2'd2;
   localparam logic [1:0] FRAME_PHASE_TRAIL = 2'd3;

   // Trailer byte lanes
   localparam logic [1:0] LANE_0 = 2'd0;
   localparam logic [1:0] LANE_1 = 2'd1;
   localparam logic [1:0] LANE_2 = 2'd2;
   localparam logic [1:0] LANE_3 = 2'd3;

   // Message ids and kinds
   localparam logic [15:0] ID_RANGE    = 16'd43;
   localparam logic [15:0] ID_GPS_EPH  = 16'd7;
   localparam logic [15:0] ID_BDS_EPH  = 16'd1696;
   localparam logic [15:0] ID_POSITION = 16'd42;

   localparam logic [2:0] KIND_OTHER    = 3'd0;
   localparam logic [2:0] KIND_RANGE    = 3'd1;
   localparam logic [2:0] KIND_GPS_EPH  = 3'd2;
   localparam logic [2:0] KIND_BDS_EPH  = 3'd3;
   localparam logic [2:0] KIND_POSITION = 3'd4;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'b0001,
      PH_HEAD  = 4'b0010,
      PH_BODY  = 4'b0100,
      PH_TRAIL = 4'b1000
   } phase_type;

   typedef enum logic [3:0] {
      SEED_IDLE = 4'b0001,
      SEED_A    = 4'b0010,
      SEED_B    = 4'b0100,
      SEED_C    = 4'b1000
   } seed_state_type;

   typedef struct packed {
      logic        busy;
      logic [31:0] poly;
      logic [31:0] seed;
   } crc_cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [1:0]  frame_phase;
      logic [16:0] byte_offset;
      logic        sync_found;
      logic [15:0] message_id;
      logic [15:0] body_length;
      logic [2:0]  message_kind;
      logic        frame_done;
      logic        crc_ok;
   } rsp_type;

   // One byte of reflected CRC, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                            input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [2:0] kind_of(input logic [15:0] id);
      logic [2:0] k;
      unique case (id)
         ID_RANGE:    k = KIND_RANGE;
         ID_GPS_EPH:  k = KIND_GPS_EPH;
         ID_BDS_EPH:  k = KIND_BDS_EPH;
         ID_POSITION: k = KIND_POSITION;
         default:     k = KIND_OTHER;
      endcase
      return k;
   endfunction

   // CRC of the sync pattern under the reset polynomial
   localparam logic [31:0] SEED_RESET =
      crc_byte(crc_byte(crc_byte(32'd0, SYNC_A, POLY_RESET), SYNC_B, POLY_RESET),
               SYNC_C, POLY_RESET);

endpackage

[rtl/core/scmd_seed_gen.sv]
`timescale 1ns / 1ps

// Holds the polynomial and the CRC of the sync pattern under it.
// After a write the seed is rebuilt one byte per cycle, in states SEED_A, SEED_B and SEED_C.
module scmd_seed_gen
   import scmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [31:0] wr_poly,
   output crc_cfg_type cfg
);

   seed_state_type state_ff, state_in;
   logic [31:0] poly_ff, poly_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] seed_ff, seed_in;

   always_comb begin
      state_in = state_ff;
      poly_in  = poly_ff;
      acc_in   = acc_ff;
      seed_in  = seed_ff;
      if (wr_en) begin
         poly_in  = wr_poly;
         acc_in   = 32'd0;
         state_in = SEED_A;
      end else begin
         unique case (state_ff)
            SEED_IDLE: ;
            SEED_A: begin
               acc_in   = crc_byte(acc_ff, SYNC_A, poly_ff);
               state_in = SEED_B;
            end
            SEED_B: begin
               acc_in   = crc_byte(acc_ff, SYNC_B, poly_ff);
               state_in = SEED_C;
            end
            SEED_C: begin
               seed_in  = crc_byte(acc_ff, SYNC_C, poly_ff);
               state_in = SEED_IDLE;
            end
            default: state_in = SEED_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEED_IDLE;
         poly_ff  <= POLY_RESET;
         seed_ff  <= SEED_RESET;
         acc_ff   <= 32'd0;
      end else begin
         state_ff <= state_in;
         poly_ff  <= poly_in;
         seed_ff  <= seed_in;
         acc_ff   <= acc_in;
      end
   end

   assign cfg.busy = (state_ff != SEED_IDLE);
   assign cfg.poly = poly_ff;
   assign cfg.seed = seed_ff;

endmodule

[rtl/core/scmd_frame_core.sv]
`timescale 1ns / 1ps

// Frame state machine: sync hunt, header capture, body count, trailer check.
// State moves on advance; rsp is the result for the byte at the input.
module scmd_frame_core
   import scmd_pkg::*;
#(
   parameter int HEADER_BYTES = 28
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [7:0]  data_byte,
   input  crc_cfg_type cfg,
   output rsp_type     rsp
);

   localparam logic [16:0] HDR = 17'(HEADER_BYTES);

   phase_type   phase_ff, phase_in;
   logic [15:0] hist_ff, hist_in;
   logic [16:0] count_ff, count_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] len_ff, len_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;

   logic [16:0] frame_end;
   logic [17:0] next_pos;
   logic [1:0]  lane;
   logic [31:0] crc_step;
   logic        done;

   assign frame_end = HDR + {1'b0, len_ff};
   assign next_pos  = {1'b0, count_ff} + 18'd1;
   assign lane      = count_ff[1:0] - frame_end[1:0];
   assign crc_step  = crc_byte(crc_ff, data_byte, cfg.poly);

   always_comb begin
      phase_in = phase_ff;
      hist_in  = hist_ff;
      count_in = count_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      done     = 1'b0;

      rsp              = '0;
      rsp.data_byte    = data_byte;

      unique case (phase_ff)
         PH_HUNT: begin
            rsp.frame_phase = FRAME_PHASE_HUNT;
            if (data_byte == SYNC_C && hist_ff == {SYNC_A, SYNC_B}) begin
               rsp.frame_phase = FRAME_PHASE_HEAD;
               rsp.byte_offset = OFS_SYNC_C;
               rsp.sync_found  = 1'b1;
               phase_in = PH_HEAD;
               hist_in  = 16'd0;
               count_in = OFS_AFTER_SYNC;
               id_in    = 16'd0;
               len_in   = 16'd0;
               rcv_in   = 32'd0;
               crc_in   = cfg.seed;
            end else begin
               hist_in = {hist_ff[7:0], data_byte};
            end
         end
         PH_HEAD: begin
            rsp.frame_phase = FRAME_PHASE_HEAD;
            crc_in = crc_step;
            unique case (count_ff)
               OFS_ID_LO:  id_in[7:0]   = data_byte;
               OFS_ID_HI:  id_in[15:8]  = data_byte;
               OFS_LEN_LO: len_in[7:0]  = data_byte;
               OFS_LEN_HI: len_in[15:8] = data_byte;
               default: ;
            endcase
            if (next_pos >= {1'b0, HDR}) begin
               phase_in = (len_in == 16'd0) ? PH_TRAIL : PH_BODY;
            end
         end
         PH_BODY: begin
            rsp.frame_phase = FRAME_PHASE_BODY;
            crc_in = crc_step;
            if (next_pos >= {1'b0, frame_end}) begin
               phase_in = PH_TRAIL;
            end
         end
         PH_TRAIL: begin
            rsp.frame_phase = FRAME_PHASE_TRAIL;
            unique case (lane)
               LANE_0: rcv_in[7:0]   = data_byte;
               LANE_1: rcv_in[15:8]  = data_byte;
               LANE_2: rcv_in[23:16] = data_byte;
               LANE_3: rcv_in[31:24] = data_byte;
               default: ;
            endcase
            done = (lane == LANE_3);
         end
         default: phase_in = PH_HUNT;
      endcase

      if (phase_ff != PH_HUNT) begin
         rsp.byte_offset  = count_ff;
         rsp.message_id   = id_in;
         rsp.body_length  = len_in;
         rsp.message_kind = kind_of(id_in);
         rsp.frame_done   = done;
         rsp.crc_ok       = done && (rcv_in == crc_ff);
         if (done) begin
            phase_in = PH_HUNT;
            count_in = 17'd0;
            hist_in  = 16'd0;
         end else begin
            count_in = 17'(next_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hist_ff  <= 16'd0;
         count_ff <= 17'd0;
         id_ff    <= 16'd0;
         len_ff   <= 16'd0;
         crc_ff   <= 32'd0;
         rcv_ff   <= 32'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hist_ff  <= hist_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

endmodule

[rtl/core/sync_crc32_message_deframer_unit.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+----------------------------------------
// req      | in        | req_valid / req_ready | req_rx_byte
// rsp      | out       | rsp_valid / rsp_ready | rsp_data_byte .. rsp_crc_ok (one per byte)
// csr      | in        | csr_valid / csr_ready | csr_crc_poly
//
// One byte per cycle sustained while rsp is not stalled and no seed rebuild runs; a byte's req
// transfer fills the input register, then the frame logic and CRC step load the result register.
// The rate is set by the byte-wide CRC step and the frame compare, both combinational.
// A csr transfer rebuilds the sync-pattern CRC seed, holding req_ready low until the rebuild ends.
// Reset is synchronous, active high; the polynomial returns to 0xEDB88320.
// A stalled rsp holds its result while the input register still takes one more byte.
module sync_crc32_message_deframer_unit
   import scmd_pkg::*;
#(
   parameter int HEADER_BYTES = 28
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_frame_phase,
   output logic [16:0] rsp_byte_offset,
   output logic        rsp_sync_found,
   output logic [15:0] rsp_message_id,
   output logic [15:0] rsp_body_length,
   output logic [2:0]  rsp_message_kind,
   output logic        rsp_frame_done,
   output logic        rsp_crc_ok,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_crc_poly
);

   crc_cfg_type cfg;
   rsp_type     core_rsp;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;

   logic req_xfer;
   logic advance;

   // writes are always taken; the seed rebuild follows
   assign csr_ready = 1'b1;

   // a byte moves on when no seed rebuild runs and the result register is free or is being drained
   assign advance   = in_valid_ff && !cfg.busy && (!out_valid_ff || rsp_ready);
   assign req_ready = (!in_valid_ff || advance) && !cfg.busy;
   assign req_xfer  = req_valid && req_ready;

   scmd_seed_gen u_seed_gen (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid && csr_ready),
      .wr_poly (csr_crc_poly),
      .cfg     (cfg)
   );

   scmd_frame_core #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .rsp       (core_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_rsp_in   = core_rsp;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_byte    = out_rsp_ff.data_byte;
   assign rsp_frame_phase  = out_rsp_ff.frame_phase;
   assign rsp_byte_offset  = out_rsp_ff.byte_offset;
   assign rsp_sync_found   = out_rsp_ff.sync_found;
   assign rsp_message_id   = out_rsp_ff.message_id;
   assign rsp_body_length  = out_rsp_ff.body_length;
   assign rsp_message_kind = out_rsp_ff.message_kind;
   assign rsp_frame_done   = out_rsp_ff.frame_done;
   assign rsp_crc_ok       = out_rsp_ff.crc_ok;

endmodule

[rtl/core/scmd_checker.sv]
`timescale 1ns / 1ps

module scmd_checker
   import scmd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_data_byte,
   input logic [1:0]  rsp_frame_phase,
   input logic [16:0] rsp_byte_offset,
   input logic        rsp_sync_found,
   input logic [15:0] rsp_message_id,
   input logic        rsp_frame_done,
   input logic        rsp_crc_ok
);

   // frame end only on a trailer byte
   a_done_in_trailer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_frame_phase == FRAME_PHASE_TRAIL)
      else $error("frame_done outside trailer");

   // crc_ok only qualifies a finished frame
   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_ok |-> rsp_frame_done)
      else $error("crc_ok without frame_done");

   // sync byte opens the header at offset 2 with nothing captured yet
   a_sync_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sync_found |->
         rsp_frame_phase == FRAME_PHASE_HEAD && rsp_byte_offset == 17'd2 &&
         rsp_message_id == 16'd0 && rsp_data_byte == SYNC_C)
      else $error("malformed sync result");

   // hunting bytes carry no frame context
   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_phase == FRAME_PHASE_HUNT |->
         rsp_byte_offset == 17'd0 && rsp_message_id == 16'd0 && !rsp_frame_done)
      else $error("hunting result with frame fields");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte) &&
         $stable(rsp_byte_offset))
      else $error("result changed while stalled");

endmodule

bind sync_crc32_message_deframer_unit scmd_checker u_scmd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_frame_phase (rsp_frame_phase),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_sync_found  (rsp_sync_found),
   .rsp_message_id  (rsp_message_id),
   .rsp_frame_done  (rsp_frame_done),
   .rsp_crc_ok      (rsp_crc_ok)
);
